FILE: design/assert_macros.svh
// assertion macros used by the detector unit rtl
// expects a clock named clk and an active-low reset named rst_n in scope
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// implication checked at every clock edge outside reset
`define ACD_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// implication checked in the cycle after the trigger
`define ACD_ASSERT_NEXT(label, trig, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (prop)) \
    else $error(msg);

`endif

FILE: design/acd_pkg.sv
// shared types and constants of the analog control change detector
// no dependencies
`default_nettype none

package acd_pkg;

  // field widths
  localparam int CH_W      = 3;
  localparam int SAMPLE_W  = 12;
  localparam int VALUE_W   = 14;
  localparam int LEVEL_W   = 7;
  localparam int GAIN_W    = 11;
  localparam int DB_W      = 10;
  localparam int THR_W     = 10;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = 11;

  // register reset values
  localparam logic [CH_W-1:0]   BEND_CHANNEL_RST = 3'd0;
  localparam logic [GAIN_W-1:0] BEND_GAIN_RST    = 11'd1008;
  localparam logic [DB_W-1:0]   BEND_DEADBAND_RST = 10'd100;
  localparam logic [THR_W-1:0]  BEND_THRESHOLD_RST = 10'd31;

  // bend value constants
  localparam logic [VALUE_W-1:0] BEND_CENTER = 14'd8192;
  localparam logic [VALUE_W-1:0] BEND_MAX    = 14'd16383;

  // ordinary channel bin guard: half bin plus guard band
  localparam logic [12:0] BIN_HALF  = 13'd16;
  localparam logic [12:0] BIN_GUARD = 13'd8;

  // divide by 1000 as multiply by ceil(2^34/1000), exact for magnitudes below 2^24
  localparam int           DIV_SHIFT = 34;
  localparam logic [24:0]  DIV_MULT  = 25'd17179870;

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_BEND_CHANNEL   = 2'd0,
    CFG_BEND_GAIN      = 2'd1,
    CFG_BEND_DEADBAND  = 2'd2,
    CFG_BEND_THRESHOLD = 2'd3
  } acd_cfg_idx_t;

  typedef struct packed {
    logic [CH_W-1:0]     channel;
    logic [SAMPLE_W-1:0] sample;
    logic                output_enable;
    logic                queue_has_room;
  } acd_in_t;

  typedef struct packed {
    logic                is_bend;
    logic [CH_W-1:0]     event_channel;
    logic [VALUE_W-1:0]  event_value;
  } acd_out_t;

endpackage

`default_nettype wire

FILE: design/analog_control_change_detector_unit.sv
// analog control change detector: per-channel level tracking and pitch bend path
// depends on acd_pkg and assert_macros.svh
`default_nettype none
`include "assert_macros.svh"

//  channel  | signals                         | direction
//  ---------+---------------------------------+-----------
//  input    | in_valid, in_ready, in_data     | sink
//  result   | out_valid, out_ready, out_data  | source
//  config   | cfg_valid, cfg_ready, cfg_index, cfg_data | sink
//
// one sample per cycle sustained while the output does not stall; four stages:
// input register, bend gain multiply, divide by 1000 (reciprocal multiply),
// clamp/deadband/dedup into the output register.
// per-channel levels and the smoothed bend update as an item leaves the input
// register; the last-sent bend value updates as an item enters the output.
// a stalled output backs up stage by stage; items with no result drop out.
// synchronous active-low reset restores register defaults; no clearing pass.

module analog_control_change_detector_unit #(
  parameter int CHANNELS = 8
) (
  input  wire logic                                 clk,
  input  wire logic                                 rst_n,
  input  wire logic                                 in_valid,
  output logic                                      in_ready,
  input  wire acd_pkg::acd_in_t                     in_data,
  output logic                                      out_valid,
  input  wire logic                                 out_ready,
  output acd_pkg::acd_out_t                         out_data,
  input  wire logic                                 cfg_valid,
  output logic                                      cfg_ready,
  input  wire logic [acd_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  wire logic [acd_pkg::CFG_DATA_W-1:0]       cfg_data
);

  import acd_pkg::*;

  localparam int IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

  // configuration registers
  logic [CH_W-1:0]   bend_channel_r;
  logic [GAIN_W-1:0] bend_gain_r;
  logic [DB_W-1:0]   bend_deadband_r;
  logic [THR_W-1:0]  bend_threshold_r;

  // state
  logic [LEVEL_W-1:0] level_r [CHANNELS];
  logic [VALUE_W-1:0] smooth_r;
  logic [VALUE_W-1:0] last_r;
  logic               last_valid_r;

  // stage 0: input register
  logic    v0_r;
  acd_in_t item0_r;

  // stage 1: gain product
  logic               v1_r;
  logic               bend1_r;
  logic [CH_W-1:0]    ch1_r;
  logic [LEVEL_W-1:0] lvl1_r;
  logic signed [25:0] prod1_r;

  // stage 2: scaled offset
  logic               v2_r;
  logic               bend2_r;
  logic [CH_W-1:0]    ch2_r;
  logic [LEVEL_W-1:0] lvl2_r;
  logic signed [15:0] quot2_r;

  // output register
  logic     out_valid_r;
  acd_out_t out_data_r;

  // configuration writes, always accepted
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bend_channel_r   <= BEND_CHANNEL_RST;
      bend_gain_r      <= BEND_GAIN_RST;
      bend_deadband_r  <= BEND_DEADBAND_RST;
      bend_threshold_r <= BEND_THRESHOLD_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (acd_cfg_idx_t'(cfg_index))
        CFG_BEND_CHANNEL:   bend_channel_r   <= cfg_data[CH_W-1:0];
        CFG_BEND_GAIN:      bend_gain_r      <= cfg_data[GAIN_W-1:0];
        CFG_BEND_DEADBAND:  bend_deadband_r  <= cfg_data[DB_W-1:0];
        CFG_BEND_THRESHOLD: bend_threshold_r <= cfg_data[THR_W-1:0];
        default: ;
      endcase
    end
  end

  // stage 0 decode
  logic               ch_ok0;
  logic               is_bend0;
  logic [IDX_W-1:0]   idx0;
  logic [LEVEL_W-1:0] cur_lvl0;
  logic [LEVEL_W-1:0] res0;
  logic [12:0]        bin_base0;
  logic [12:0]        smp13;
  logic               lvl_change0;
  logic               lvl_write0;
  logic               lvl_emit0;
  logic [VALUE_W-1:0] wide0;
  logic signed [14:0] diff0;
  logic [14:0]        mag0;
  logic               bend_step0;
  logic signed [14:0] quarter0;
  logic [VALUE_W-1:0] smooth_nxt;
  logic signed [13:0] centered0;
  logic signed [11:0] gain0;
  logic signed [25:0] prod0;
  logic               bend_emit0;
  logic               keep0;

  assign ch_ok0   = 32'(item0_r.channel) < CHANNELS;
  assign is_bend0 = item0_r.channel == bend_channel_r;
  assign idx0     = IDX_W'(item0_r.channel);
  assign cur_lvl0 = level_r[idx0];

  // ordinary channel: leave the 32-count bin by more than the guard
  assign res0        = item0_r.sample[SAMPLE_W-1:5];
  assign bin_base0   = {1'b0, cur_lvl0, 5'd0};
  assign smp13       = {1'b0, item0_r.sample};
  assign lvl_change0 = (smp13 > bin_base0 + BIN_HALF + BIN_HALF + BIN_GUARD) ||
                       (smp13 + BIN_GUARD < bin_base0);
  assign lvl_write0  = ch_ok0 && !is_bend0 && lvl_change0 &&
                       (!item0_r.output_enable || item0_r.queue_has_room);
  assign lvl_emit0   = ch_ok0 && !is_bend0 && lvl_change0 &&
                       item0_r.output_enable && item0_r.queue_has_room;

  // bend channel: quarter step toward the widened sample past the threshold
  assign wide0      = {item0_r.sample, 2'b00};
  assign diff0      = $signed({1'b0, wide0}) - $signed({1'b0, smooth_r});
  assign mag0       = diff0[14] ? 15'(-diff0) : 15'(diff0);
  assign bend_step0 = ch_ok0 && is_bend0 && (mag0 > {5'd0, bend_threshold_r});
  assign quarter0   = (diff0 + (diff0[14] ? 15'sd3 : 15'sd0)) >>> 2;
  assign smooth_nxt = smooth_r + quarter0[VALUE_W-1:0];

  // offset from centre times gain
  assign centered0  = $signed({~smooth_nxt[13], smooth_nxt[12:0]});
  assign gain0      = $signed({1'b0, bend_gain_r});
  assign prod0      = 26'(centered0) * 26'(gain0);
  assign bend_emit0 = bend_step0 && item0_r.output_enable && item0_r.queue_has_room;
  assign keep0      = lvl_emit0 || bend_emit0;

  // stage 2 divide by 1000, truncating toward zero
  logic [25:0] abs1;
  logic [48:0] recip1;
  logic [14:0] q1;
  logic signed [15:0] quot1;

  assign abs1   = prod1_r[25] ? 26'(-prod1_r) : 26'(prod1_r);
  assign recip1 = 49'(abs1[23:0]) * 49'(DIV_MULT);
  assign q1     = recip1[48:DIV_SHIFT];
  assign quot1  = prod1_r[25] ? -$signed({1'b0, q1}) : $signed({1'b0, q1});

  // stage 3 clamp, deadband and duplicate check
  logic signed [16:0] sum2;
  logic signed [16:0] db2;
  logic [VALUE_W-1:0] fixed2;
  logic               emit2;

  assign sum2 = 17'(quot2_r) + 17'sd8192;
  assign db2  = $signed({7'd0, bend_deadband_r});

  always_comb begin
    if (sum2 < 17'sd0) begin
      fixed2 = '0;
    end else if (sum2 > $signed({3'd0, BEND_MAX})) begin
      fixed2 = BEND_MAX;
    end else if (sum2 > 17'sd8192 - db2 && sum2 < 17'sd8192 + db2) begin
      fixed2 = BEND_CENTER;
    end else begin
      fixed2 = sum2[VALUE_W-1:0];
    end
  end

  assign emit2 = !bend2_r || !last_valid_r || (fixed2 != last_r);

  // stage handshakes, each stage moves when the one after has room or its item is dropped
  logic out_free;
  logic move2;
  logic ready2;
  logic move1;
  logic ready1;
  logic move0;

  assign out_free = !out_valid_r || out_ready;
  assign move2    = v2_r && (!emit2 || out_free);
  assign ready2   = !v2_r || move2;
  assign move1    = v1_r && ready2;
  assign ready1   = !v1_r || move1;
  assign move0    = v0_r && (!keep0 || ready1);
  assign in_ready = !v0_r || move0;

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r         <= 1'b0;
      v1_r         <= 1'b0;
      v2_r         <= 1'b0;
      out_valid_r  <= 1'b0;
      smooth_r     <= BEND_CENTER;
      last_valid_r <= 1'b0;
      for (int k = 0; k < CHANNELS; k++) begin
        level_r[k] <= '0;
      end
    end else begin
      if (in_ready) begin
        v0_r <= in_valid;
      end
      if (ready1) begin
        v1_r <= move0 && keep0;
      end
      if (ready2) begin
        v2_r <= move1;
      end
      out_valid_r <= (out_valid_r && !out_ready) || (move2 && emit2);
      if (move0 && bend_step0) begin
        smooth_r <= smooth_nxt;
      end
      if (move0 && lvl_write0) begin
        level_r[idx0] <= res0;
      end
      if (move2 && emit2 && bend2_r) begin
        last_valid_r <= 1'b1;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item0_r <= in_data;
    end
    if (move0 && keep0) begin
      bend1_r <= is_bend0;
      ch1_r   <= item0_r.channel;
      lvl1_r  <= res0;
      prod1_r <= prod0;
    end
    if (move1) begin
      bend2_r <= bend1_r;
      ch2_r   <= ch1_r;
      lvl2_r  <= lvl1_r;
      quot2_r <= quot1;
    end
    if (move2 && emit2) begin
      out_data_r.is_bend       <= bend2_r;
      out_data_r.event_channel <= ch2_r;
      out_data_r.event_value   <= bend2_r ? fixed2 : {7'd0, lvl2_r};
      if (bend2_r) begin
        last_r <= fixed2;
      end
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // checks
  `ACD_ASSERT_NEXT(a_last_sent_tracks, move2 && emit2 && bend2_r,
    last_valid_r && last_r == out_data_r.event_value, "last sent bend value not updated")
  `ACD_ASSERT(a_level_fits, (out_valid_r && !out_data_r.is_bend) |->
    out_data_r.event_value[VALUE_W-1:LEVEL_W] == '0, "control event value wider than a level")
  `ACD_ASSERT(a_bad_channel_dropped, (v0_r && !ch_ok0) |-> !keep0 && !lvl_write0,
    "sample on a missing channel acted upon")
  `ACD_ASSERT_NEXT(a_smooth_hold, v0_r && !bend_step0, $stable(smooth_r),
    "bend smoothing moved without a step")

endmodule

`default_nettype wire

FILE: tb/sv/tb_top.sv
// self-checking bench for the analog control change detector unit
// predicts level and pitch bend events per sample and checks them in order
// depends on acd_pkg and analog_control_change_detector_unit

module tb_top;
  import acd_pkg::*;

  localparam int NUM_CH         = 8;
  localparam int DRAIN_CYCLES   = 12;
  localparam int STALL_LIMIT    = 2000;
  localparam int HOLDOFF_CYCLES = 300;
  localparam int PHASES         = 8;
  localparam int PHASE_ITEMS    = 160;
  localparam int STRESS_PHASE   = 3;

  logic                  clk       = 1'b0;
  logic                  rst_n     = 1'b0;
  logic                  in_valid  = 1'b0;
  acd_in_t               in_data   = '0;
  logic                  out_ready = 1'b0;
  logic                  cfg_valid = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data  = '0;
  logic                  in_ready;
  logic                  out_valid;
  acd_out_t              out_data;
  logic                  cfg_ready;

  // samples waiting to be offered and events waiting to come out
  acd_in_t  sample_queue[$];
  acd_out_t expected_events[$];

  // predicted state of the block
  logic [CH_W-1:0]    bend_ch_cfg;
  logic [GAIN_W-1:0]  gain_cfg;
  logic [DB_W-1:0]    deadband_cfg;
  logic [THR_W-1:0]   threshold_cfg;
  logic [LEVEL_W-1:0] level_now [NUM_CH];
  logic [VALUE_W-1:0] smooth_now;
  logic [15:0]        last_bend_sent;

  int  error_count  = 0;
  bit  sample_taken = 1'b0;
  bit  steady_send  = 1'b0;
  bit  holdoff_req  = 1'b0;
  int  gen_sample [NUM_CH];

  analog_control_change_detector_unit #(.CHANNELS(NUM_CH)) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // clock
  initial begin
    forever #10 clk = ~clk;
  end

  // work out the event, if any, that one accepted sample causes
  task automatic predict_event(input acd_in_t item);
    int       wide, diff, mag, scaled, lvl_mid;
    acd_out_t ev;
    if (item.channel == bend_ch_cfg) begin
      wide = int'(item.sample) << 2;
      diff = wide - int'(smooth_now);
      mag  = (diff < 0) ? -diff : diff;
      if (mag <= int'(threshold_cfg)) return;
      // quarter step toward the sample, truncating toward zero
      smooth_now = VALUE_W'(int'(smooth_now) + diff / 4);
      scaled = (int'(smooth_now) - 8192) * int'(gain_cfg);
      scaled = scaled / 1000 + 8192;
      // clamp first, deadband only inside the range
      if (scaled < 0) scaled = 0;
      else if (scaled > 16383) scaled = 16383;
      else if (scaled > 8192 - int'(deadband_cfg) && scaled < 8192 + int'(deadband_cfg))
        scaled = 8192;
      if (item.output_enable && item.queue_has_room && 16'(scaled) != last_bend_sent) begin
        last_bend_sent   = 16'(scaled);
        ev.is_bend       = 1'b1;
        ev.event_channel = item.channel;
        ev.event_value   = VALUE_W'(scaled);
        expected_events.push_back(ev);
      end
    end else begin
      // outside the bin plus guard band moves the level
      lvl_mid = (int'(level_now[item.channel]) << 5) + 16;
      if (int'(item.sample) <= lvl_mid + 24 && int'(item.sample) >= lvl_mid - 24) return;
      if (!item.output_enable) begin
        level_now[item.channel] = item.sample[SAMPLE_W-1:5];
        return;
      end
      if (!item.queue_has_room) return;
      level_now[item.channel] = item.sample[SAMPLE_W-1:5];
      ev.is_bend       = 1'b0;
      ev.event_channel = item.channel;
      ev.event_value   = VALUE_W'(item.sample[SAMPLE_W-1:5]);
      expected_events.push_back(ev);
    end
  endtask

  // port monitor: predict on input transactions, check output transactions
  always @(posedge clk) begin : watch_ports
    acd_out_t want;
    if (rst_n) begin
      if (in_valid && in_ready) begin
        sample_taken = 1'b1;
        predict_event(in_data);
      end
      if (out_valid && out_ready) begin
        if (expected_events.size() == 0) begin
          $error("unexpected event: is_bend %0d channel %0d value %0d",
                 out_data.is_bend, out_data.event_channel, out_data.event_value);
          error_count++;
        end else begin
          want = expected_events.pop_front();
          if (out_data.is_bend !== want.is_bend) begin
            $error("is_bend: expected %0d, actual %0d", want.is_bend, out_data.is_bend);
            error_count++;
          end
          if (out_data.event_channel !== want.event_channel) begin
            $error("event_channel: expected %0d, actual %0d",
                   want.event_channel, out_data.event_channel);
            error_count++;
          end
          if (out_data.event_value !== want.event_value) begin
            $error("event_value: expected %0d, actual %0d",
                   want.event_value, out_data.event_value);
            error_count++;
          end
        end
      end
    end
  end

  // sample driver: bursts of random length with random gaps
  always @(negedge clk) begin : drive_samples
    logic    nxt_valid;
    acd_in_t nxt_data;
    int      burst_left;
    int      gap_left;
    nxt_valid = in_valid;
    nxt_data  = in_data;
    if (!rst_n) begin
      nxt_valid = 1'b0;
    end else begin
      if (sample_taken) begin
        nxt_valid    = 1'b0;
        sample_taken = 1'b0;
      end
      if (!nxt_valid && sample_queue.size() > 0) begin
        if (gap_left > 0 && !steady_send) begin
          gap_left--;
        end else begin
          nxt_data  = sample_queue.pop_front();
          nxt_valid = 1'b1;
          if (burst_left > 1) begin
            burst_left--;
          end else begin
            burst_left = $urandom_range(1, 24);
            gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
          end
        end
      end
    end
    in_valid <= nxt_valid;
    in_data  <= nxt_data;
  end

  // result receiver: stall pattern of its own plus one long hold-off
  always @(negedge clk) begin : drive_ready
    int ready_mode;
    int mode_left;
    int holdoff_left;
    bit holdoff_done;
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (holdoff_req && !holdoff_done) begin
        holdoff_left = HOLDOFF_CYCLES;
        holdoff_done = 1'b1;
      end
      if (holdoff_left > 0) begin
        holdoff_left--;
        out_ready <= 1'b0;
      end else begin
        if (mode_left == 0) begin
          ready_mode = $urandom_range(0, 3);
          mode_left  = $urandom_range(8, 80);
        end else begin
          mode_left--;
        end
        case (ready_mode)
          2:       out_ready <= ($urandom_range(0, 1) == 1);
          3:       out_ready <= ($urandom_range(0, 4) == 0);
          default: out_ready <= 1'b1;
        endcase
      end
    end
  end

  // watchdog on cycles with no transaction on any port
  always @(posedge clk) begin : watchdog
    int quiet_cycles;
    if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
      quiet_cycles = 0;
    else
      quiet_cycles++;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  // one register write, mirrored into the predictor when it is taken
  task automatic write_reg(input acd_cfg_idx_t idx, input int value);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= CFG_DATA_W'(value);
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      CFG_BEND_CHANNEL:   bend_ch_cfg   = CH_W'(value);
      CFG_BEND_GAIN:      gain_cfg      = GAIN_W'(value);
      CFG_BEND_DEADBAND:  deadband_cfg  = DB_W'(value);
      CFG_BEND_THRESHOLD: threshold_cfg = THR_W'(value);
      default: ;
    endcase
  endtask

  task automatic queue_sample(input int ch, input int smp, input bit oe, input bit room);
    acd_in_t item;
    item.channel        = CH_W'(ch);
    item.sample         = SAMPLE_W'(smp);
    item.output_enable  = oe;
    item.queue_has_room = room;
    sample_queue.push_back(item);
  endtask

  // random samples: mostly gliding values per channel, some jumps and extremes
  task automatic queue_random_samples(input int count, input int bend_ch);
    int ch, pick, smp;
    for (int n = 0; n < count; n++) begin
      ch   = ($urandom_range(0, 99) < 35) ? bend_ch : $urandom_range(0, NUM_CH - 1);
      pick = $urandom_range(0, 99);
      if (pick < 55) begin
        if ($urandom_range(0, 1) == 0)
          smp = gen_sample[ch] + $urandom_range(0, 48) - 24;
        else
          smp = gen_sample[ch] + $urandom_range(0, 600) - 300;
      end else if (pick < 90) begin
        smp = $urandom_range(0, 4095);
      end else begin
        smp = ($urandom_range(0, 1) == 0) ? 0 : 4095;
      end
      if (smp < 0) smp = 0;
      if (smp > 4095) smp = 4095;
      gen_sample[ch] = smp;
      queue_sample(ch, smp, $urandom_range(0, 9) != 0, $urandom_range(0, 9) != 0);
    end
  endtask

  // let all queued samples go and every event arrive, then let the pipe empty
  task automatic wait_drained();
    @(posedge clk);
    while (sample_queue.size() != 0 || in_valid) @(posedge clk);
    @(negedge clk);
    while (expected_events.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  // test sequence
  initial begin : run_test
    int phase_bend_ch [PHASES] = '{0, 7, 3, 5, 0, 2, 6, 1};
    int phase_gain    [PHASES] = '{1008, 2047, 0, 1000, 1, 1500, 2047, 500};
    int phase_db      [PHASES] = '{100, 0, 1023, 1023, 0, 50, 512, 1};
    int phase_thr     [PHASES] = '{31, 0, 1023, 0, 1023, 8, 100, 255};

    bend_ch_cfg    = BEND_CHANNEL_RST;
    gain_cfg       = BEND_GAIN_RST;
    deadband_cfg   = BEND_DEADBAND_RST;
    threshold_cfg  = BEND_THRESHOLD_RST;
    smooth_now     = BEND_CENTER;
    last_bend_sent = 16'hffff;
    foreach (level_now[k]) level_now[k] = '0;
    foreach (gen_sample[k]) gen_sample[k] = 2048;

    repeat (11) @(negedge clk);
    rst_n <= 1'b1;

    // directed: bin guard edges, silent tracking, queue full, bend extremes
    queue_sample(1, 0, 1, 1);
    queue_sample(1, 40, 1, 1);
    queue_sample(1, 41, 1, 1);
    queue_sample(1, 4095, 1, 1);
    queue_sample(2, 4095, 0, 1);
    queue_sample(2, 0, 1, 0);
    queue_sample(2, 0, 1, 1);
    queue_sample(3, 3000, 1, 0);
    queue_sample(7, 4095, 1, 1);
    queue_sample(7, 0, 1, 1);
    queue_sample(4, 2047, 1, 1);
    queue_sample(5, 1234, 0, 0);
    for (int n = 0; n < 5; n++) queue_sample(0, 4095, 1, 1);
    for (int n = 0; n < 5; n++) queue_sample(0, 0, 1, 1);
    queue_sample(0, 0, 0, 1);
    queue_sample(0, 4095, 1, 0);
    queue_sample(0, 2048, 1, 1);
    queue_sample(0, 2048, 1, 1);
    queue_sample(0, 2049, 1, 1);
    wait_drained();

    // random phases, each with its own register settings
    for (int p = 0; p < PHASES; p++) begin
      write_reg(CFG_BEND_CHANNEL, phase_bend_ch[p]);
      write_reg(CFG_BEND_GAIN, phase_gain[p]);
      write_reg(CFG_BEND_DEADBAND, phase_db[p]);
      write_reg(CFG_BEND_THRESHOLD, phase_thr[p]);
      @(negedge clk);
      cfg_valid <= 1'b0;
      if (p == STRESS_PHASE) begin
        // receiver holds off while samples keep coming, filling the pipe
        steady_send = 1'b1;
        holdoff_req = 1'b1;
      end
      queue_random_samples(PHASE_ITEMS, phase_bend_ch[p]);
      wait_drained();
      steady_send = 1'b0;
    end

    if (error_count == 0)
      $display("Verification passed");
    else
      $display("Verification failed");
    $finish;
  end

endmodule

FILE: filelist.f
+incdir+design
design/acd_pkg.sv
design/analog_control_change_detector_unit.sv
tb/sv/tb_top.sv
